// File: design/bevq_pkg.sv
// Package for the button event qualifier: shared types and constants.
// Used by bevq_eval and button_event_qualifier_top; depends on nothing.
`default_nettype none

package bevq_pkg;

	localparam logic [2:0] FILTER_COUNT = 3'd5;

	typedef enum logic [2:0] {
		EV_PRESSED  = 3'd0,
		EV_RELEASED = 3'd1,
		EV_DOUBLE   = 3'd2,
		EV_TRIPLE   = 3'd3,
		EV_LONG     = 3'd4,
		EV_REPEAT   = 3'd5
	} ev_kind_t;

	typedef enum logic [2:0] {
		REG_IDLE_LEVELS  = 3'd0,
		REG_BUTTON_COUNT = 3'd1,
		REG_HOLD_LONG    = 3'd2,
		REG_HOLD_REPEAT  = 3'd3,
		REG_CLICK_WINDOW = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  idle_levels;
		logic [3:0]  button_count;
		logic [31:0] hold_long;
		logic [31:0] hold_repeat;
		logic [31:0] click_window;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  dsum;
		logic [2:0]  scnt;
		logic        stable;
		logic [31:0] press_t;
		logic [31:0] rep_t;
		logic [31:0] lpress_t;
		logic        lpress_v;
		logic [1:0]  clicks;
		logic        hold_act;
		logic        hold_rep;
	} btn_state_t;

	typedef struct packed {
		logic [2:0]  button_index;
		logic [2:0]  event_kind;
		logic [31:0] held_ticks;
		logic        last_event;
	} event_t;

endpackage

`default_nettype wire

// File: design/bevq_eval.sv
// Per-sample evaluation: debounce filter, press/release, click and hold logic.
// Pure combinational; depends on bevq_pkg.
`default_nettype none

module bevq_eval
	import bevq_pkg::*;
(
	input  wire cfg_t         cfg,
	input  wire logic [2:0]   button,
	input  wire logic         raw_level,
	input  wire logic [31:0]  now_tick,
	input  wire btn_state_t   cur,
	output btn_state_t        nxt,
	output event_t [2:0]      events,
	output logic [1:0]        ev_cnt
);

	function automatic event_t mk_event(logic [2:0] b, ev_kind_t k, logic [31:0] t);
		event_t e;
		e.button_index = b;
		e.event_kind   = k;
		e.held_ticks   = t;
		e.last_event   = 1'b0;
		return e;
	endfunction

	logic [2:0]  sum_n, cnt_n;
	logic        lvl, settled, idle, changed, pressed, released;
	logic [31:0] pt, rt, d_press, d_rep, d_lp;
	logic        ha, hr, fire_rep, fire_long, dbl, tpl;
	logic [1:0]  clicks, clicks_inc, n;
	logic [3:0]  cand_vld;
	event_t [3:0] cand;

	always_comb begin
		sum_n = cur.dsum + 3'(raw_level);
		cnt_n = (cur.scnt < FILTER_COUNT) ? cur.scnt + 3'd1 : cur.scnt;
		nxt = cur;
		nxt.dsum = sum_n;
		nxt.scnt = cnt_n;
		lvl = 1'b0;
		settled = 1'b0;
		if (cnt_n >= FILTER_COUNT) begin
			if (sum_n == FILTER_COUNT) begin
				nxt.dsum = FILTER_COUNT - 3'd1;
				lvl = 1'b1;
				settled = 1'b1;
			end else if (sum_n == 3'd0) begin
				settled = 1'b1;
			end else begin
				// disagreeing samples in the window: restart the filter
				nxt.dsum = 3'd0;
				nxt.scnt = 3'd0;
			end
		end

		idle     = cfg.idle_levels[button];
		changed  = settled && (lvl != cur.stable);
		pressed  = changed && (lvl != idle);
		released = changed && (lvl == idle);

		pt = pressed ? now_tick : (released ? 32'd0 : cur.press_t);
		rt = released ? 32'd0 : cur.rep_t;
		d_press = now_tick - pt;
		d_rep   = now_tick - rt;
		d_lp    = now_tick - cur.lpress_t;

		ha = cur.hold_act;
		hr = cur.hold_rep;
		fire_rep = 1'b0;
		if (settled && (lvl != idle) && (d_press >= cfg.hold_long)) begin
			if (ha) begin
				if (d_rep >= cfg.hold_repeat) begin
					rt = now_tick;
					fire_rep = 1'b1;
				end
			end else begin
				rt = now_tick;
				ha = 1'b1;
				hr = 1'b0;
			end
		end

		clicks = cur.clicks;
		clicks_inc = cur.clicks + 2'd1;
		dbl = 1'b0;
		tpl = 1'b0;
		if (pressed) begin
			if (!cur.lpress_v || (d_lp >= cfg.click_window)) begin
				clicks = 2'd0;
			end else if (clicks_inc == 2'd1) begin
				clicks = clicks_inc;
				dbl = 1'b1;
			end else begin
				clicks = 2'd0;
				tpl = 1'b1;
			end
			nxt.lpress_t = now_tick;
			nxt.lpress_v = 1'b1;
		end
		if (released) begin
			ha = 1'b0;
		end

		fire_long = 1'b0;
		if (settled && !hr && ha) begin
			hr = 1'b1;
			fire_long = 1'b1;
		end

		nxt.stable   = settled ? lvl : cur.stable;
		nxt.press_t  = pt;
		nxt.rep_t    = rt;
		nxt.clicks   = clicks;
		nxt.hold_act = ha;
		nxt.hold_rep = hr;

		// candidates in output order, then packed down to at most three
		cand_vld = {fire_rep, fire_long, changed, dbl | tpl};
		cand[0] = mk_event(button, dbl ? EV_DOUBLE : EV_TRIPLE, 32'd0);
		cand[1] = mk_event(button, pressed ? EV_PRESSED : EV_RELEASED, 32'd0);
		cand[2] = mk_event(button, EV_LONG, d_press);
		cand[3] = mk_event(button, EV_REPEAT, d_press);

		events = '0;
		n = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (cand_vld[i] && (n != 2'd3)) begin
				events[n] = cand[i];
				n = n + 2'd1;
			end
		end
		if (n != 2'd0) begin
			events[n - 2'd1].last_event = 1'b1;
		end
		ev_cnt = n;
	end

endmodule

`default_nettype wire

// File: design/button_event_qualifier_top.sv
// Button event qualifier top: one input word in s1, evaluation, 3-deep result buffer.
// Result words come from the result buffer, loaded from s1 once it will be empty.
// Throughput: one sample per cycle if it yields at most one event and m_tready is high;
// a sample with more events holds the input side until the buffer is down to its last word.
// Reset (arst_n, async): all per-button state cleared, registers to their defaults.
// Depends on bevq_pkg and bevq_eval.
`default_nettype none

module button_event_qualifier_top
	import bevq_pkg::*;
#(
	parameter int BUTTONS = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [39:0]  s_tdata,   // button[2:0], raw_level[3], now_tick[35:4]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [39:0]       m_tdata,   // button_index[2:0], held_ticks[34:3]
	output logic [2:0]        m_tuser,   // event_kind[2:0]
	output logic              m_tlast
);

	localparam int BIDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

	cfg_t cfg_q;

	logic              item_vld_s1;
	logic [2:0]        button_s1;
	logic              raw_s1;
	logic [31:0]       now_s1;

	btn_state_t        st_q [BUTTONS];
	logic [BIDX_W-1:0] bidx_s1;
	logic              in_range_s1;
	btn_state_t        cur_st, nxt_st;

	event_t [2:0]      new_ev;
	logic [1:0]        new_cnt;
	event_t [2:0]      ev_q;
	logic [1:0]        ev_cnt_q;
	logic              eval_go;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_levels  <= 8'd0;
			cfg_q.button_count <= 4'd8;
			cfg_q.hold_long    <= 32'd3000;
			cfg_q.hold_repeat  <= 32'd1000;
			cfg_q.click_window <= 32'd300;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				REG_IDLE_LEVELS:  cfg_q.idle_levels  <= pwdata[7:0];
				REG_BUTTON_COUNT: cfg_q.button_count <= pwdata[3:0];
				REG_HOLD_LONG:    cfg_q.hold_long    <= pwdata;
				REG_HOLD_REPEAT:  cfg_q.hold_repeat  <= pwdata;
				REG_CLICK_WINDOW: cfg_q.click_window <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_IDLE_LEVELS:  prdata = 32'(cfg_q.idle_levels);
			REG_BUTTON_COUNT: prdata = 32'(cfg_q.button_count);
			REG_HOLD_LONG:    prdata = cfg_q.hold_long;
			REG_HOLD_REPEAT:  prdata = cfg_q.hold_repeat;
			REG_CLICK_WINDOW: prdata = cfg_q.click_window;
			default:          prdata = 32'd0;
		endcase
	end

	// input stage; evaluated once the result buffer will be empty
	assign eval_go  = item_vld_s1 &&
	                  ((ev_cnt_q == 2'd0) || ((ev_cnt_q == 2'd1) && m_tready));
	assign s_tready = !item_vld_s1 || eval_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			item_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			button_s1 <= s_tdata[2:0];
			raw_s1    <= s_tdata[3];
			now_s1    <= s_tdata[35:4];
		end
	end

	assign in_range_s1 = ({1'b0, button_s1} < cfg_q.button_count) &&
	                     (int'(button_s1) < BUTTONS);
	assign bidx_s1 = BIDX_W'(button_s1);
	assign cur_st  = st_q[bidx_s1];

	bevq_eval u_eval (
		.cfg       (cfg_q),
		.button    (button_s1),
		.raw_level (raw_s1),
		.now_tick  (now_s1),
		.cur       (cur_st),
		.nxt       (nxt_st),
		.events    (new_ev),
		.ev_cnt    (new_cnt)
	);

	// per-button state, written back as the sample leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUTTONS; i++) begin
				st_q[i] <= '0;
			end
		end else if (eval_go && in_range_s1) begin
			st_q[bidx_s1] <= nxt_st;
		end
	end

	// result buffer: slot 0 is on the port, pops shift the rest down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_cnt_q <= 2'd0;
		end else if (eval_go) begin
			ev_cnt_q <= in_range_s1 ? new_cnt : 2'd0;
		end else if (m_tvalid && m_tready) begin
			ev_cnt_q <= ev_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_go) begin
			ev_q <= new_ev;
		end else if (m_tvalid && m_tready) begin
			ev_q[0] <= ev_q[1];
			ev_q[1] <= ev_q[2];
		end
	end

	assign m_tvalid = (ev_cnt_q != 2'd0);
	assign m_tdata  = {5'd0, ev_q[0].held_ticks, ev_q[0].button_index};
	assign m_tuser  = ev_q[0].event_kind;
	assign m_tlast  = ev_q[0].last_event;

`ifndef ASSERT_OFF
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> item_vld_s1)
		else $error("input stalled with no sample held");
	a_last_word_tagged: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (ev_cnt_q == 2'd1)) |-> m_tlast)
		else $error("final buffered word lacks tlast");
	a_no_early_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_cnt_q == 2'd2 || ev_cnt_q == 2'd3) |-> !m_tlast)
		else $error("tlast set before the final word");
	a_filter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(item_vld_s1 && in_range_s1) |-> (cur_st.scnt <= FILTER_COUNT))
		else $error("sample count beyond filter length");
`endif

endmodule

`default_nettype wire

// File: dv/bevq_event_checker.sv
// Checker for the button event qualifier: follows register writes, predicts the
// events of every accepted sample and compares them with the result words.
// Depends on bevq_pkg.
`default_nettype none

module bevq_event_checker
	import bevq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [39:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [39:0] m_tdata,
	input  wire logic [2:0]  m_tuser,
	input  wire logic        m_tlast,
	output int               fails,
	output int               pending
);

	cfg_t       live_cfg;
	btn_state_t btn_st [8];
	event_t     expected_events [$];

	function automatic event_t make_event(logic [2:0] b, ev_kind_t kind, logic [31:0] t);
		event_t e;
		e.button_index = b;
		e.event_kind   = kind;
		e.held_ticks   = t;
		e.last_event   = 1'b0;
		return e;
	endfunction

	task automatic qualify_sample(input logic [2:0] b, input logic raw, input logic [31:0] now);
		btn_state_t st;
		event_t     outs [$];
		logic       lvl, idle, pressed, released, fire_long, fire_rep;
		logic [31:0] held;
		if ({1'b0, b} >= live_cfg.button_count)
			return;
		idle      = live_cfg.idle_levels[b];
		st        = btn_st[b];
		lvl       = raw;
		pressed   = 1'b0;
		released  = 1'b0;
		fire_long = 1'b0;
		fire_rep  = 1'b0;

		st.dsum = st.dsum + {2'b0, raw};
		if (st.scnt < FILTER_COUNT)
			st.scnt = st.scnt + 3'd1;
		if (st.scnt < FILTER_COUNT) begin
			btn_st[b] = st;
			return;
		end
		if (st.dsum == FILTER_COUNT) begin
			st.dsum = FILTER_COUNT - 3'd1;
			lvl = 1'b1;
		end else if (st.dsum == 3'd0) begin
			lvl = 1'b0;
		end else begin
			// window disagreed: restart the filter
			st.dsum = 3'd0;
			st.scnt = 3'd0;
			btn_st[b] = st;
			return;
		end

		if (lvl != st.stable) begin
			if (lvl != idle) begin
				pressed    = 1'b1;
				st.press_t = now;
			end else begin
				released   = 1'b1;
				st.press_t = '0;
				st.rep_t   = '0;
			end
		end
		st.stable = lvl;

		held = now - st.press_t;
		if (lvl != idle && held >= live_cfg.hold_long) begin
			if (st.hold_act) begin
				if (now - st.rep_t >= live_cfg.hold_repeat) begin
					st.rep_t = now;
					fire_rep = 1'b1;
				end
			end else begin
				st.rep_t    = now;
				st.hold_act = 1'b1;
				st.hold_rep = 1'b0;
			end
		end

		if (pressed) begin
			if (!st.lpress_v || now - st.lpress_t >= live_cfg.click_window) begin
				st.clicks = 2'd0;
			end else begin
				st.clicks = st.clicks + 2'd1;
				if (st.clicks == 2'd1) begin
					outs.push_back(make_event(b, EV_DOUBLE, '0));
				end else begin
					outs.push_back(make_event(b, EV_TRIPLE, '0));
					st.clicks = 2'd0;
				end
			end
			st.lpress_t = now;
			st.lpress_v = 1'b1;
			outs.push_back(make_event(b, EV_PRESSED, '0));
		end
		if (released) begin
			outs.push_back(make_event(b, EV_RELEASED, '0));
			st.hold_act = 1'b0;
		end
		if (!st.hold_rep && st.hold_act) begin
			st.hold_rep = 1'b1;
			fire_long   = 1'b1;
		end
		if (fire_long)
			outs.push_back(make_event(b, EV_LONG, now - st.press_t));
		if (fire_rep)
			outs.push_back(make_event(b, EV_REPEAT, now - st.press_t));

		btn_st[b] = st;
		while (outs.size() > 3)
			void'(outs.pop_back());
		if (outs.size() > 0)
			outs[outs.size() - 1].last_event = 1'b1;
		foreach (outs[i])
			expected_events.push_back(outs[i]);
	endtask

	task automatic check_word();
		event_t want;
		if (expected_events.size() == 0) begin
			$error("unexpected word: button_index %0d event_kind %0d held_ticks %0d last_event %0d",
				m_tdata[2:0], m_tuser, m_tdata[34:3], m_tlast);
			fails++;
			return;
		end
		want = expected_events.pop_front();
		if (m_tdata[2:0] !== want.button_index) begin
			$error("button_index: expected %0d, actual %0d", want.button_index, m_tdata[2:0]);
			fails++;
		end
		if (m_tuser !== want.event_kind) begin
			$error("event_kind: expected %0d, actual %0d", want.event_kind, m_tuser);
			fails++;
		end
		if (m_tdata[34:3] !== want.held_ticks) begin
			$error("held_ticks: expected %0d, actual %0d", want.held_ticks, m_tdata[34:3]);
			fails++;
		end
		if (m_tlast !== want.last_event) begin
			$error("last_event: expected %0d, actual %0d", want.last_event, m_tlast);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_cfg.idle_levels  = 8'h00;
			live_cfg.button_count = 4'd8;
			live_cfg.hold_long    = 32'd3000;
			live_cfg.hold_repeat  = 32'd1000;
			live_cfg.click_window = 32'd300;
			foreach (btn_st[i]) begin
				btn_st[i] = '0;
				btn_st[i].stable = live_cfg.idle_levels[i];
			end
			expected_events.delete();
			fails   = 0;
			pending = 0;
		end else begin
			// compare first so a word never meets an expectation made at the same edge
			if (m_tvalid && m_tready)
				check_word();
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_IDLE_LEVELS:  live_cfg.idle_levels  = pwdata[7:0];
					REG_BUTTON_COUNT: live_cfg.button_count = pwdata[3:0];
					REG_HOLD_LONG:    live_cfg.hold_long    = pwdata;
					REG_HOLD_REPEAT:  live_cfg.hold_repeat  = pwdata;
					REG_CLICK_WINDOW: live_cfg.click_window = pwdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				qualify_sample(s_tdata[2:0], s_tdata[3], s_tdata[35:4]);
			pending = expected_events.size();
		end
	end

endmodule

`default_nettype wire

// File: dv/tb_button_event_qualifier_top.sv
// Testbench top for button_event_qualifier_top: reset, register phases, sample
// runs with random gaps and output stalls; verdict from bevq_event_checker.
// Depends on bevq_pkg, bevq_event_checker and the block itself.
`default_nettype none

module tb_button_event_qualifier_top
	import bevq_pkg::*;
();

	localparam int LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [39:0] s_tdata;   // button[2:0], raw_level[3], now_tick[35:4]
	logic        m_tvalid, m_tready;
	logic [39:0] m_tdata;   // button_index[2:0], held_ticks[34:3]
	logic [2:0]  m_tuser;   // event_kind[2:0]
	logic        m_tlast;

	int          fails, pending;
	int          cycles = 0;
	int          stall_left = 0;
	bit          calm;
	logic [31:0] tick;

	button_event_qualifier_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	bevq_event_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.fails    (fails),
		.pending  (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// output stalls in bursts
	always @(negedge clk) begin
		if (calm) begin
			m_tready   <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 7) == 0)
				stall_left <= $urandom_range(1, 17);
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// one sample word at the current tick; valid stays up until the next call
	task automatic push_sample(input logic [2:0] b, input logic lvl);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, tick, lvl, b};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic hold_level(input logic [2:0] b, input logic lvl, input int n,
			input logic [31:0] step);
		repeat (n) begin
			push_sample(b, lvl);
			tick += step;
		end
	endtask

	// drain all expected words, then let the block finish any quiet sample
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_traffic(input int bc, input int step_max, input int n_items);
		int         counted, tries, len, r;
		logic [2:0] b;
		logic       lvl;
		counted = 0;
		tries   = 0;
		b       = '0;
		while (counted < n_items && tries < 4 * n_items + 16) begin
			// stay on the same button often so presses, clicks and holds build up
			if ($urandom_range(0, 9) >= 6) begin
				if (bc > 0 && $urandom_range(0, 4) != 0)
					b = 3'($urandom_range(0, bc - 1));
				else
					b = 3'($urandom_range(0, 7));
			end
			r   = $urandom_range(0, 9);
			lvl = 1'($urandom_range(0, 1));
			len = (r < 7) ? $urandom_range(5, 16) : $urandom_range(1, 4);
			repeat (len) begin
				if (r >= 7)
					lvl = 1'($urandom_range(0, 1));
				push_sample(b, lvl);
				tick += ($urandom_range(0, 31) == 0) ? $urandom() : $urandom_range(0, step_max);
				tries++;
				if (b < bc)
					counted++;
			end
		end
	endtask

	task automatic run_phase(input logic [7:0] idle, input logic [3:0] bc,
			input logic [31:0] long_t, input logic [31:0] rep_t, input logic [31:0] win_t,
			input int step_max, input int n_items);
		settle();
		reg_write(REG_IDLE_LEVELS, {24'b0, idle});
		reg_write(REG_BUTTON_COUNT, {28'b0, bc});
		reg_write(REG_HOLD_LONG, long_t);
		reg_write(REG_HOLD_REPEAT, rep_t);
		reg_write(REG_CLICK_WINDOW, win_t);
		random_traffic(bc, step_max, n_items);
	endtask

	initial begin
		clk      = 1'b0;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		calm     = 1'b0;
		tick     = 32'hFFFF_FFF0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset register values: first press near tick wrap, long hold
		// across the wrap, noisy window before the release
		hold_level(3'd7, 1'b1, 5, 32'd1);
		hold_level(3'd7, 1'b1, 3, 32'd1600);
		hold_level(3'd7, 1'b0, 6, 32'd1);
		hold_level(3'd0, 1'b1, 5, 32'd1);
		hold_level(3'd0, 1'b0, 6, 32'd100);

		run_phase(8'h00, 4'd8, 32'd40, 32'd9, 32'd60, 4, 45);
		run_phase(8'hFF, 4'd8, 32'd1, 32'd1, 32'hFFFF_FFFF, 3, 40);
		run_phase(8'($urandom_range(0, 255)), 4'd3, 32'd25, 32'd6, 32'd30, 3, 40);
		run_phase(8'hA5, 4'd0, 32'd5, 32'd5, 32'd5, 2, 4);
		run_phase(8'($urandom_range(0, 255)), 4'd8, 32'd0, 32'd0, 32'd0, 3, 30);
		run_phase(8'($urandom_range(0, 255)), 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1,
			2, 30);
		calm = 1'b1;
		run_phase(8'h5A, 4'd5, 32'd30, 32'd7, 32'd45, 4, 45);

		settle();
		repeat (8) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
design/bevq_pkg.sv
design/bevq_eval.sv
design/button_event_qualifier_top.sv
dv/bevq_event_checker.sv
dv/tb_button_event_qualifier_top.sv
